/* hdl/gbts_pkg.sv */
// gbts_pkg: shared types and constants of the gap buffer text store
// no dependencies
`timescale 1ns / 1ps

package gbts_pkg;

  localparam int unsigned CAPACITY_DEF = 4096;

  localparam int unsigned RUNE_W   = 32;
  localparam int unsigned OFFSET_W = 13;
  localparam int unsigned LEN_W    = 13;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [RUNE_W-1:0] RUNE_NL = 32'd10;
  localparam logic [RUNE_W-1:0] RUNE_CR = 32'd13;
  localparam logic [RUNE_W-1:0] MARKER_RESET = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_CRLF_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRLF_MARKER = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [OFFSET_W-1:0] offset;
    logic                nl;
    logic [RUNE_W-1:0]   wr_rune;
    logic [RUNE_W-1:0]   marker;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EVAL,
    B_READ,
    B_CR_CHK,
    B_MOVE,
    B_MOVE_WR,
    B_APPLY,
    B_FIN
  } b_state_t;

endpackage

/* hdl/gbts_in_if.sv */
// gbts_in_if: input word channel, valid/ready with operation payload
// depends on gbts_pkg
`timescale 1ns / 1ps

interface gbts_in_if
  import gbts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [OFFSET_W-1:0] offset;
  logic [RUNE_W-1:0]   rune_in;

  modport source (output valid, mode, offset, rune_in, input ready);
  modport sink   (input valid, mode, offset, rune_in, output ready);
endinterface

/* hdl/gbts_out_if.sv */
// gbts_out_if: result word channel, valid/ready with result payload
// depends on gbts_pkg
`timescale 1ns / 1ps

interface gbts_out_if
  import gbts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [RUNE_W-1:0]   rune_out;
  logic [LEN_W-1:0]    text_length;
  logic                insert_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, rune_out, text_length, insert_count, status, input ready);
  modport sink   (input valid, rune_out, text_length, insert_count, status, output ready);
endinterface

/* hdl/gbts_cfg_if.sv */
// gbts_cfg_if: configuration write channel, register index and data
// depends on gbts_pkg
`timescale 1ns / 1ps

interface gbts_cfg_if
  import gbts_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [RUNE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/gbts_front.sv */
// gbts_front: accepts input words, holds config registers, decodes commands
// depends on gbts_pkg, gbts_in_if, gbts_cfg_if
`timescale 1ns / 1ps

module gbts_front
  import gbts_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  gbts_in_if.sink       in_if,
  gbts_cfg_if.sink      cfg_if,
  input  logic          q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic              crlf_mode_r;
  logic [RUNE_W-1:0] crlf_marker_r;
  logic              nl;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crlf_mode_r   <= 1'b0;
      crlf_marker_r <= MARKER_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_CRLF_MODE:   crlf_mode_r   <= cfg_if.data[0];
        CFG_CRLF_MARKER: crlf_marker_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  // newline in crlf mode is stored as the marker
  assign nl = crlf_mode_r && (in_if.rune_in == RUNE_NL);

  always_comb begin
    q_cmd.op      = op_t'(in_if.mode);
    q_cmd.offset  = in_if.offset;
    q_cmd.nl      = nl;
    q_cmd.wr_rune = nl ? crlf_marker_r : in_if.rune_in;
    q_cmd.marker  = crlf_marker_r;
  end

endmodule

/* hdl/gbts_cmd_fifo.sv */
// gbts_cmd_fifo: two-entry command queue between front and back
// depends on gbts_pkg
`timescale 1ns / 1ps

module gbts_cmd_fifo
  import gbts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  cmd_t       entry_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("fifo count overflow");
`endif

endmodule

/* hdl/gbts_back.sv */
// gbts_back: executes commands on the rune memory, moves the gap, drives results
// depends on gbts_pkg, gbts_out_if
`timescale 1ns / 1ps

module gbts_back
  import gbts_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  gbts_out_if.source out_if
);

  localparam int unsigned PTR_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W  = (PTR_W > OFFSET_W) ? PTR_W : OFFSET_W;
  localparam logic [PTR_W-1:0] CAP_P = PTR_W'(CAPACITY);

  logic [RUNE_W-1:0] mem_r [CAPACITY];
  logic [RUNE_W-1:0] rdata_r;

  b_state_t          state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [PTR_W-1:0]  gf_r, gf_nxt, gl_r, gl_nxt;
  logic              merge_r, merge_nxt;
  logic              dir_right_r, dir_right_nxt;
  logic [RUNE_W-1:0] res_rune_r, res_rune_nxt;
  logic              res_cnt_r, res_cnt_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [RUNE_W-1:0]   out_rune_r, out_rune_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                out_cnt_r, out_cnt_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;

  logic              re, we;
  logic [ADDR_W-1:0] ra, wa;
  logic [RUNE_W-1:0] wd;

  logic [PTR_W-1:0]  tlen, offp;
  logic [CMP_W-1:0]  tlen_c, off_c;
  logic              out_free;

  function automatic logic [ADDR_W-1:0] phys(input logic [PTR_W-1:0] off,
                                             input logic [PTR_W-1:0] gf,
                                             input logic [PTR_W-1:0] gl);
    logic [PTR_W-1:0] idx;
    idx = (off < gf) ? off : PTR_W'(gl + (off - gf));
    return idx[ADDR_W-1:0];
  endfunction

  assign tlen     = PTR_W'(CAP_P - PTR_W'(gl_r - gf_r));
  assign tlen_c   = CMP_W'(tlen);
  assign off_c    = CMP_W'(cmd_r.offset);
  assign offp     = PTR_W'(cmd_r.offset);
  assign out_free = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem_r[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      gf_r        <= '0;
      gl_r        <= CAP_P;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gf_r        <= gf_nxt;
      gl_r        <= gl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    merge_r     <= merge_nxt;
    dir_right_r <= dir_right_nxt;
    res_rune_r  <= res_rune_nxt;
    res_cnt_r   <= res_cnt_nxt;
    res_st_r    <= res_st_nxt;
    out_rune_r  <= out_rune_nxt;
    out_len_r   <= out_len_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_st_r    <= out_st_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    gf_nxt        = gf_r;
    gl_nxt        = gl_r;
    merge_nxt     = merge_r;
    dir_right_nxt = dir_right_r;
    res_rune_nxt  = res_rune_r;
    res_cnt_nxt   = res_cnt_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_rune_nxt  = out_rune_r;
    out_len_nxt   = out_len_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    q_pop         = 1'b0;
    re            = 1'b0;
    ra            = '0;
    we            = 1'b0;
    wa            = '0;
    wd            = '0;

    case (state_r)
      B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = B_EVAL;
        end
      end
      B_EVAL: begin
        res_rune_nxt = '0;
        res_cnt_nxt  = 1'b0;
        res_st_nxt   = ST_OK;
        merge_nxt    = 1'b0;
        case (cmd_r.op)
          OP_READ: begin
            if (off_c >= tlen_c) begin
              res_rune_nxt = RUNE_NL;
              state_nxt    = B_FIN;
            end else begin
              re        = 1'b1;
              ra        = phys(offp, gf_r, gl_r);
              state_nxt = B_READ;
            end
          end
          OP_INSERT: begin
            if (off_c > tlen_c) begin
              res_st_nxt = ST_RANGE;
              state_nxt  = B_FIN;
            end else if (cmd_r.nl && (offp != '0)) begin
              re        = 1'b1;
              ra        = phys(PTR_W'(offp - 1'b1), gf_r, gl_r);
              state_nxt = B_CR_CHK;
            end else if (gf_r == gl_r) begin
              res_st_nxt = ST_FULL;
              state_nxt  = B_FIN;
            end else begin
              state_nxt = B_MOVE;
            end
          end
          OP_DELETE: begin
            if (off_c >= tlen_c) begin
              res_st_nxt = ST_RANGE;
              state_nxt  = B_FIN;
            end else begin
              state_nxt = B_MOVE;
            end
          end
          default: begin
            state_nxt = B_FIN;
          end
        endcase
      end
      B_READ: begin
        res_rune_nxt = rdata_r;
        state_nxt    = B_FIN;
      end
      B_CR_CHK: begin
        if (rdata_r == RUNE_CR) begin
          merge_nxt = 1'b1;
          state_nxt = B_MOVE;
        end else if (gf_r == gl_r) begin
          res_st_nxt = ST_FULL;
          state_nxt  = B_FIN;
        end else begin
          state_nxt = B_MOVE;
        end
      end
      B_MOVE: begin
        if (offp < gf_r) begin
          re            = 1'b1;
          ra            = ADDR_W'(gf_r - 1'b1);
          dir_right_nxt = 1'b0;
          state_nxt     = B_MOVE_WR;
        end else if (offp > gf_r) begin
          re            = 1'b1;
          ra            = ADDR_W'(gl_r);
          dir_right_nxt = 1'b1;
          state_nxt     = B_MOVE_WR;
        end else begin
          state_nxt = B_APPLY;
        end
      end
      B_MOVE_WR: begin
        we = 1'b1;
        wd = rdata_r;
        if (dir_right_r) begin
          wa     = ADDR_W'(gf_r);
          gf_nxt = PTR_W'(gf_r + 1'b1);
          gl_nxt = PTR_W'(gl_r + 1'b1);
        end else begin
          wa     = ADDR_W'(gl_r - 1'b1);
          gf_nxt = PTR_W'(gf_r - 1'b1);
          gl_nxt = PTR_W'(gl_r - 1'b1);
        end
        state_nxt = B_MOVE;
      end
      B_APPLY: begin
        if (cmd_r.op == OP_DELETE) begin
          gl_nxt = PTR_W'(gl_r + 1'b1);
        end else if (merge_r) begin
          // carriage return before the point becomes the marker
          we = 1'b1;
          wa = ADDR_W'(gf_r - 1'b1);
          wd = cmd_r.marker;
        end else begin
          we          = 1'b1;
          wa          = ADDR_W'(gf_r);
          wd          = cmd_r.wr_rune;
          gf_nxt      = PTR_W'(gf_r + 1'b1);
          res_cnt_nxt = 1'b1;
        end
        state_nxt = B_FIN;
      end
      B_FIN: begin
        out_valid_nxt = 1'b1;
        out_rune_nxt  = res_rune_r;
        out_len_nxt   = tlen_c[LEN_W-1:0];
        out_cnt_nxt   = res_cnt_r;
        out_st_nxt    = res_st_r;
        state_nxt     = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.rune_out     = out_rune_r;
  assign out_if.text_length  = out_len_r;
  assign out_if.insert_count = out_cnt_r;
  assign out_if.status       = out_st_r;

`ifndef SYNTH
  a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
    gf_r <= gl_r) else $error("gap start past gap end");

  a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    gl_r <= CAP_P) else $error("gap end past capacity");

  a_move_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MOVE_WR) && !dir_right_r |=> gf_r == PTR_W'($past(gf_r) - 1'b1))
    else $error("left copy did not shift gap");

  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FIN) |-> out_free) else $error("result slot busy at finish");
`endif

endmodule

/* hdl/gap_buffer_text_store.sv */
// gap_buffer_text_store: top level, front decoder, command queue, back executor
// depends on gbts_pkg, the three channel interfaces, gbts_front, gbts_cmd_fifo, gbts_back
//
//   port     dir  payload                                      word
//   in_if    in   mode, offset, rune_in                        one operation
//   out_if   out  rune_out, text_length, insert_count, status  one result per operation
//   cfg_if   in   index, data                                  one register write
//
// read: eval, a memory read, finish; past the end it goes from eval to finish.
// insert and delete: eval, a carriage return check for a newline past offset zero, gap
// move, apply, finish; the gap moves a rune at a time over the single memory read
// port, one read then one write per copied rune; range, full and no-op end in finish.
// reset is synchronous, active low; the memory holds no reset value and needs no sweep.
// up to two operations queue behind the one at work; out_if stalls hold the result register.
`timescale 1ns / 1ps

module gap_buffer_text_store
  import gbts_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gbts_in_if.sink     in_if,
  gbts_out_if.source  out_if,
  gbts_cfg_if.sink    cfg_if
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t push_cmd, pop_cmd;

  gbts_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  gbts_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  gbts_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule
